// File: sv/dag_check_bitrow_dfs_macros.svh
// Assertion macros shared by the graph acyclicity checker RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef DAG_CHECK_BITROW_DFS_MACROS_SVH
`define DAG_CHECK_BITROW_DFS_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DCB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define DCB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dcb_pkg.sv
// Types and constants for the graph acyclicity checker.
// No dependencies; imported by dcb_engine, dag_check_bitrow_dfs and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package dcb_pkg;

    localparam int ROW_W  = 32;   // adjacency row transaction width
    localparam int CNT_W  = 6;    // vertex_count register width
    localparam int ADDR_W = 3;    // APB byte address width

    // Register indexes (paddr[2])
    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] VC_RESET = 6'd32;

    typedef enum logic [1:0] {
        S_LOAD,   // accept adjacency rows
        S_ROOT,   // pick next unvisited root
        S_EXAM,   // examine top of stack using fetched row
        S_POP     // wait for the new top from the stack memory
    } state_t;

    typedef struct packed {
        logic row_fire;    // a row transaction is accepted this cycle
        logic slot_free;   // output register can take a result this cycle
        logic cfg_write;   // vertex_count is written this cycle
    } eng_ctrl_t;

    typedef struct packed {
        logic load_ready;  // engine accepts rows
        logic res_valid;   // result produced this cycle
        logic res_acyclic; // result value
    } eng_stat_t;

endpackage

`default_nettype wire

// File: sv/dcb_engine.sv
// Row storage, search stack and depth-first search sequencer.
// Depends on dcb_pkg and dag_check_bitrow_dfs_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dag_check_bitrow_dfs_macros.svh"

module dcb_engine
    import dcb_pkg::*;
#(
    parameter int MAX_VERTICES = 32
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire eng_ctrl_t            ctrl,
    input  wire logic [ROW_W-1:0]     row_edges,
    input  wire logic [CNT_W-1:0]     vertex_total,
    output eng_stat_t                 stat
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Control state
    state_t                  state_reg, state_next;
    logic [CW-1:0]           rows_loaded_reg, rows_loaded_next;
    logic [CW-1:0]           root_reg, root_next;
    logic [CW-1:0]           depth_reg, depth_next;
    logic [VW-1:0]           top_reg, top_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] on_stack_reg, on_stack_next;

    // Memories: adjacency rows and stack entries below the top
    logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_rdata_reg;
    logic [VW-1:0]           stack_mem [MAX_VERTICES];
    logic [VW-1:0]           stack_rdata_reg;

    logic                    row_wr_en;
    logic                    row_rd_en;
    logic [VW-1:0]           row_rd_addr;
    logic                    stk_wr_en;
    logic [VW-1:0]           stk_wr_addr;
    logic [VW-1:0]           stk_wr_data;
    logic                    stk_rd_en;
    logic [VW-1:0]           stk_rd_addr;

    logic [CW-1:0]           n_eff;
    logic [MAX_VERTICES-1:0] vmask;
    logic [MAX_VERTICES-1:0] row_masked;
    logic [MAX_VERTICES-1:0] cand;
    logic                    pick_any;
    logic [VW-1:0]           pick_idx;
    logic [CW-1:0]           depth_m1;
    logic [CW-1:0]           depth_m2;
    logic [CW-1:0]           loaded_p1;
    logic [MAX_VERTICES-1:0] root_bit;
    logic [MAX_VERTICES-1:0] top_bit;
    logic [MAX_VERTICES-1:0] pick_bit;

    // Vertex mask and masked row
    assign n_eff = vertex_total[CW-1:0];
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            vmask[i] = (CW'(i) < n_eff);
        end
    end
    assign row_masked = row_edges[MAX_VERTICES-1:0] & vmask;

    // Candidates: neighbors that are unvisited or on the stack
    assign cand = row_rdata_reg & (~visited_reg | on_stack_reg);

    // Find the lowest candidate
    always_comb
    begin
        pick_any = 1'b0;
        pick_idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick_any = 1'b1;
                pick_idx = VW'(i);
            end
        end
    end

    assign depth_m1  = depth_reg - CW'(1);
    assign depth_m2  = depth_reg - CW'(2);
    assign loaded_p1 = rows_loaded_reg + CW'(1);
    assign root_bit  = MAX_VERTICES'(1) << root_reg[VW-1:0];
    assign top_bit   = MAX_VERTICES'(1) << top_reg;
    assign pick_bit  = MAX_VERTICES'(1) << pick_idx;

    // Sequencer: next state and memory controls
    always_comb
    begin
        state_next       = state_reg;
        rows_loaded_next = rows_loaded_reg;
        root_next        = root_reg;
        depth_next       = depth_reg;
        top_next         = top_reg;
        visited_next     = visited_reg;
        on_stack_next    = on_stack_reg;
        row_wr_en        = 1'b0;
        row_rd_en        = 1'b0;
        row_rd_addr      = '0;
        stk_wr_en        = 1'b0;
        stk_wr_addr      = '0;
        stk_wr_data      = '0;
        stk_rd_en        = 1'b0;
        stk_rd_addr      = '0;
        stat.load_ready  = 1'b0;
        stat.res_valid   = 1'b0;
        stat.res_acyclic = 1'b1;

        case (state_reg)
            S_LOAD:
            begin
                stat.load_ready = 1'b1;
                if (ctrl.cfg_write)
                begin
                    rows_loaded_next = '0;
                end
                else if (ctrl.row_fire)
                begin
                    row_wr_en = 1'b1;
                    if (loaded_p1 == n_eff)
                    begin
                        rows_loaded_next = '0;
                        root_next        = '0;
                        depth_next       = '0;
                        visited_next     = '0;
                        on_stack_next    = '0;
                        state_next       = S_ROOT;
                    end
                    else
                    begin
                        rows_loaded_next = loaded_p1;
                    end
                end
            end

            S_ROOT:
            begin
                if (root_reg == n_eff)
                begin
                    // All roots done without a cycle
                    if (ctrl.slot_free)
                    begin
                        stat.res_valid   = 1'b1;
                        stat.res_acyclic = 1'b1;
                        state_next       = S_LOAD;
                    end
                end
                else if (visited_reg[root_reg[VW-1:0]])
                begin
                    root_next = root_reg + CW'(1);
                end
                else
                begin
                    top_next      = root_reg[VW-1:0];
                    depth_next    = CW'(1);
                    visited_next  = visited_reg | root_bit;
                    on_stack_next = on_stack_reg | root_bit;
                    row_rd_en     = 1'b1;
                    row_rd_addr   = root_reg[VW-1:0];
                    state_next    = S_EXAM;
                end
            end

            S_EXAM:
            begin
                if (!pick_any)
                begin
                    // Pop the top node
                    on_stack_next = on_stack_reg & ~top_bit;
                    depth_next    = depth_m1;
                    if (depth_reg == CW'(1))
                    begin
                        root_next  = root_reg + CW'(1);
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        stk_rd_en   = 1'b1;
                        stk_rd_addr = depth_m2[VW-1:0];
                        state_next  = S_POP;
                    end
                end
                else if (on_stack_reg[pick_idx])
                begin
                    // Back edge: cycle found
                    if (ctrl.slot_free)
                    begin
                        stat.res_valid   = 1'b1;
                        stat.res_acyclic = 1'b0;
                        state_next       = S_LOAD;
                    end
                end
                else
                begin
                    // Push the candidate and fetch its row
                    stk_wr_en     = 1'b1;
                    stk_wr_addr   = depth_m1[VW-1:0];
                    stk_wr_data   = top_reg;
                    top_next      = pick_idx;
                    depth_next    = depth_reg + CW'(1);
                    visited_next  = visited_reg | pick_bit;
                    on_stack_next = on_stack_reg | pick_bit;
                    row_rd_en     = 1'b1;
                    row_rd_addr   = pick_idx;
                end
            end

            S_POP:
            begin
                top_next    = stack_rdata_reg;
                row_rd_en   = 1'b1;
                row_rd_addr = stack_rdata_reg;
                state_next  = S_EXAM;
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            rows_loaded_reg <= '0;
            root_reg        <= '0;
            depth_reg       <= '0;
            top_reg         <= '0;
            visited_reg     <= '0;
            on_stack_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_loaded_reg <= rows_loaded_next;
            root_reg        <= root_next;
            depth_reg       <= depth_next;
            top_reg         <= top_next;
            visited_reg     <= visited_next;
            on_stack_reg    <= on_stack_next;
        end
    end

    // Adjacency row memory: one write, one registered read.
    // Rows are only written while loading, so reads never overlap a write.
    always_ff @(posedge clk)
    begin
        if (row_wr_en)
        begin
            row_mem[rows_loaded_reg[VW-1:0]] <= row_masked;
        end
        if (row_rd_en)
        begin
            row_rdata_reg <= row_mem[row_rd_addr];
        end
    end

    // Stack memory; a pop reads an entry written by an earlier push
    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stack_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en)
        begin
            stack_rdata_reg <= stack_mem[stk_rd_addr];
        end
    end

    // Checks
    `DCB_ASSERT_IMP(a_depth_bound, 1'b1, depth_reg <= CW'(MAX_VERTICES), "stack depth overflow")
    `DCB_ASSERT_IMP(a_depth_live, state_reg == S_EXAM || state_reg == S_POP, depth_reg != '0, "search step with empty stack")
    `DCB_ASSERT_IMP(a_top_marked, state_reg == S_EXAM, on_stack_reg[top_reg] && visited_reg[top_reg], "top node not marked")
    `DCB_ASSERT_IMP(a_res_slot, stat.res_valid, ctrl.slot_free && (state_reg == S_ROOT || state_reg == S_EXAM), "result without free slot")
    `DCB_ASSERT_NXT(a_res_reload, stat.res_valid, state_reg == S_LOAD && rows_loaded_reg == '0, "no return to loading after result")

endmodule

`default_nettype wire

// File: sv/dag_check_bitrow_dfs.sv
// Directed graph acyclicity checker: APB register, handshakes, result register.
// Depends on dcb_pkg and dcb_engine.
//
// Usage:
//   Write vertex_count (address 0, low 6 bits; 0 acts as 1, values above
//   MAX_VERTICES saturate) while the block is idle. Then send the graph as
//   vertex_count row transactions on row_edges, row 0 first; bit j of a row
//   is an edge to vertex j, bits at or above the vertex count are dropped.
//   After the last row the block runs a depth-first search and returns one
//   is_acyclic transaction: 1 for no directed cycle, 0 for a cycle.
// Timing:
//   Rows are taken one per cycle while in_stall is low. in_stall stays high
//   from the last row until the search ends. A root check (which also pushes
//   a new root) is an S_ROOT step, any other push an S_EXAM step, and a pop
//   an S_EXAM step plus an S_POP step when the new top is read back from the
//   stack memory; the adjacency and stack memories have registered reads.
//   The result is registered; the next graph can load while it waits.
// Reset and stall:
//   Reset sets vertex_count to 32 and returns to loading row 0. If out_stall
//   holds a result and the next search finishes, that search waits.
`timescale 1ns / 1ps
`default_nettype none

module dag_check_bitrow_dfs
    import dcb_pkg::*;
#(
    parameter int MAX_VERTICES = 32
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // APB configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Row channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ROW_W-1:0]  row_edges,
    // Result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   is_acyclic
);

    logic [CNT_W-1:0] vc_reg;
    logic [CNT_W-1:0] vc_eff;
    logic             cfg_write;
    logic             out_valid_reg;
    logic             is_acyclic_reg;
    eng_ctrl_t        ctrl;
    eng_stat_t        stat;

    // Register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata    = (paddr[2] == REG_VERTEX_COUNT)
                       ? {{(32-CNT_W){1'b0}}, vc_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (cfg_write)
        begin
            vc_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Clamp the vertex count into the supported range
    always_comb
    begin
        if (vc_reg == '0)
        begin
            vc_eff = CNT_W'(1);
        end
        else if (vc_reg > CNT_W'(MAX_VERTICES))
        begin
            vc_eff = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            vc_eff = vc_reg;
        end
    end

    // Engine handshake
    assign in_stall       = !stat.load_ready;
    assign ctrl.row_fire  = in_valid && !in_stall;
    assign ctrl.slot_free = !out_valid_reg || !out_stall;
    assign ctrl.cfg_write = cfg_write;

    dcb_engine #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .row_edges    (row_edges),
        .vertex_total (vc_eff),
        .stat         (stat)
    );

    // Result register: load on a new result, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid)
        begin
            is_acyclic_reg <= stat.res_acyclic;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_acyclic = is_acyclic_reg;

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for dag_check_bitrow_dfs: streams adjacency rows, predicts the acyclic flag.
// Depends on dcb_pkg and the dag_check_bitrow_dfs RTL; needs no other files.
`timescale 1ns / 1ps

// Predicts one acyclic flag per completed graph and checks results in order
class acyclic_scoreboard;
    logic [31:0] adjacency [32];
    logic [5:0]  vertex_count_reg;
    int unsigned rows_in;
    bit          acyclic_q [$];
    int unsigned failures;

    function new();
        vertex_count_reg = dcb_pkg::VC_RESET;
        rows_in          = 0;
        failures         = 0;
    endfunction

    // Zero reads as one vertex, anything above 32 saturates
    function int unsigned active_vertices();
        if (vertex_count_reg == 0)
            return 1;
        if (vertex_count_reg > 32)
            return 32;
        return vertex_count_reg;
    endfunction

    // A register write abandons any partly loaded graph
    function void write_vertex_count(logic [5:0] value);
        vertex_count_reg = value;
        rows_in          = 0;
    endfunction

    // Iterative depth-first search; true when a back edge or self-loop shows up
    function bit has_cycle(int unsigned n);
        logic [31:0] seen;
        logic [31:0] active;
        logic [31:0] cand;
        int          path [32];
        int          depth;
        int          node;
        int          nxt;
        seen   = '0;
        active = '0;
        for (int root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            path[0]      = root;
            depth        = 1;
            seen[root]   = 1'b1;
            active[root] = 1'b1;
            while (depth > 0)
            begin
                node = path[depth-1];
                cand = adjacency[node] & (~seen | active);
                if (cand == '0)
                begin
                    // pop: no unexplored or on-path neighbor left
                    active[node] = 1'b0;
                    depth--;
                end
                else
                begin
                    nxt = 0;
                    for (int j = 31; j >= 0; j--)
                        if (cand[j])
                            nxt = j;
                    if (active[nxt])
                        return 1'b1;
                    path[depth] = nxt;
                    depth++;
                    seen[nxt]   = 1'b1;
                    active[nxt] = 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Store an accepted row; the last row of a graph yields one expected flag
    function void note_row(logic [31:0] row);
        int unsigned n;
        logic [31:0] keep;
        n    = active_vertices();
        keep = (n >= 32) ? '1 : ((32'd1 << n) - 1);
        if (rows_in >= n)
            rows_in = 0;
        adjacency[rows_in] = row & keep;
        rows_in++;
        if (rows_in == n)
        begin
            acyclic_q.push_back(!has_cycle(n));
            rows_in = 0;
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic got);
        bit want;
        if (acyclic_q.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("%0t: result %0d arrived with nothing expected", $realtime, got);
            return;
        end
        want = acyclic_q.pop_front();
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
                $display("%0t: is_acyclic expected %0d, got %0d", $realtime, want, got);
        end
    endfunction
endclass

module tb;
    import dcb_pkg::*;

    localparam int ROW_TARGET     = 1050;
    localparam int CALM_FROM      = 900;
    localparam int SETTLE_CYCLES  = 150;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [ADDR_W-1:0] VC_ADDR = {REG_VERTEX_COUNT, 2'b00};

    typedef enum int {
        GRAPH_DAG,
        GRAPH_DAG_BACK,
        GRAPH_RANDOM
    } graph_shape_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [ROW_W-1:0]  row_edges;
    logic              out_valid;
    logic              out_stall;
    logic              is_acyclic;

    acyclic_scoreboard sb = new();
    logic [31:0] graph_rows [32];
    int          rows_sent = 0;
    bit          calm = 1'b0;
    bit          long_hold_req = 1'b0;

    dag_check_bitrow_dfs i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_edges  (row_edges),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_acyclic (is_acyclic)
    );

    always #5 clk = ~clk;

    // Offer one row, with an occasional idle burst first, and hold it until taken
    task automatic send_row(input logic [31:0] row);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_edges <= row;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_row(row);
        rows_sent++;
        calm = (rows_sent >= CALM_FROM);
    endtask

    task automatic send_graph(input int count);
        for (int r = 0; r < count; r++)
            send_row(graph_rows[r]);
    endtask

    // Drop valid, wait for every pending flag, then let any search wind down
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.acyclic_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Two-phase register write: setup, then access until pready
    task automatic write_count(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VC_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_vertex_count(value[5:0]);
    endtask

    // Fill graph_rows: a DAG over a random vertex order, optionally one edge
    // against that order, or sparse random rows; junk above the vertex count
    task automatic build_graph(input int n, input graph_shape_t shape);
        int          order [32];
        int          rank [32];
        int          j;
        int          t;
        int          dens;
        int          u;
        int          v;
        logic [31:0] keep;
        logic [31:0] bits;
        keep = (n >= 32) ? '1 : ((32'd1 << n) - 1);
        for (int i = 0; i < 32; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < n; i++)
            rank[order[i]] = i;
        dens = $urandom_range(0, 100);
        for (int r = 0; r < n; r++)
        begin
            graph_rows[r] = $urandom & ~keep;
            if (shape == GRAPH_RANDOM)
            begin
                bits = $urandom;
                repeat ($urandom_range(0, 3)) bits &= $urandom;
                graph_rows[r] |= bits & keep;
            end
            else
            begin
                for (int c = 0; c < n; c++)
                    if (rank[r] < rank[c] && $urandom_range(0, 99) < dens)
                        graph_rows[r][c] = 1'b1;
            end
        end
        if (shape == GRAPH_DAG_BACK)
        begin
            u = $urandom_range(0, n - 1);
            v = $urandom_range(0, n - 1);
            if (rank[u] < rank[v])
            begin
                t = u;
                u = v;
                v = t;
            end
            graph_rows[u][v] = 1'b1;
        end
    endtask

    // Result side: check accepted transactions, stall in random bursts or one long hold
    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(is_acyclic);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            else if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 10);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet = 0;
            else if (rst_n)
                quiet++;
        end
        $display("dag_check_bitrow_dfs: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int           n;
        int           graphs;
        int           pick;
        int           phase;
        logic [5:0]   count;
        logic [31:0]  value;
        graph_shape_t shape;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        row_edges <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset vertex count: one full-size graph
        build_graph(32, GRAPH_DAG);
        send_graph(32);
        settle();

        // Zero count acts as one vertex: empty row, self-loop, ignored high bits
        write_count(32'hFFFF_FFC0);
        send_row(32'h0000_0000);
        send_row(32'h0000_0001);
        send_row(32'hFFFF_FFFE);
        settle();

        // Two vertices: two-node cycle, single edge, then a half-loaded graph
        write_count(32'd2);
        send_row(32'h0000_0002);
        send_row(32'h0000_0001);
        send_row(32'h0000_0002);
        send_row(32'h0000_0000);
        send_row(32'hFFFF_FFFF);
        settle();

        // Three vertices: full forward edges, then a three-node ring
        write_count(32'd3);
        send_row(32'hFFFF_FFFE);
        send_row(32'hFFFF_FFFC);
        send_row(32'hFFFF_FFF8);
        send_row(32'h0000_0002);
        send_row(32'h0000_0004);
        send_row(32'h0000_0001);
        settle();

        // Random phases, each with its own vertex count
        phase = 0;
        while (rows_sent < ROW_TARGET)
        begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       count = 6'd0;
                1:       count = 6'd1;
                2:       count = 6'd32;
                3:       count = 6'($urandom_range(33, 63));
                4, 5, 6: count = 6'($urandom_range(9, 31));
                default: count = 6'($urandom_range(1, 8));
            endcase
            if (phase == 2)
                count = 6'd4;
            value = $urandom_range(0, 1) ? {26'($urandom), count} : {26'd0, count};
            write_count(value);
            n      = sb.active_vertices();
            graphs = (n > 16) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            if (phase == 2)
            begin
                // hold the result side off while rows keep coming
                graphs        = 12;
                long_hold_req = 1'b1;
            end
            repeat (graphs)
            begin
                pick  = $urandom_range(0, 9);
                shape = (pick < 4) ? GRAPH_DAG : (pick < 7) ? GRAPH_DAG_BACK : GRAPH_RANDOM;
                build_graph(n, shape);
                send_graph(n);
            end
            // Sometimes leave a graph half loaded for the next write to drop
            if (n > 1 && $urandom_range(0, 4) == 0)
            begin
                build_graph(n, GRAPH_RANDOM);
                send_graph($urandom_range(1, n - 1));
            end
            settle();
            phase++;
        end

        if (sb.failures == 0 && sb.acyclic_q.size() == 0)
            $display("dag_check_bitrow_dfs: match");
        else
            $display("dag_check_bitrow_dfs: mismatch");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/dcb_pkg.sv
sv/dcb_engine.sv
sv/dag_check_bitrow_dfs.sv
test/tb.sv
